FILE: design/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    // fixed field widths
    localparam int ADDR_W     = 48;
    localparam int BYTES_W    = 33;
    localparam int REQ_W      = 32;
    localparam int LIMIT_W    = 32;
    localparam int INIT_W     = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // allocation granule
    localparam int ALIGN_BYTES = 16;

    // result codes
    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_NULL    = 3'd1,
        STATUS_OOM     = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_UNKNOWN = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE    = 2'd0,
        CFG_HEAP_LIMIT   = 2'd1,
        CFG_INITIAL_HEAP = 2'd2
    } cfg_idx_t;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

`default_nettype wire

FILE: design/ffha_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/first_fit_heap_allocator_top.sv
// First-fit heap allocator. Each transaction is an allocate (cmd 0) or a
// free (cmd 1) and gives exactly one result transaction with a data address
// and a status. The block table lives in RAMs with a registered read, and a
// small sequencer walks the address-ordered list one entry per clock; besides
// the walk, an item passes through decode and, as needed, setup, growth and
// split writes. The input is not ready while an item is at work. A finished
// result waits in an output register, and the next input is taken meanwhile.
// PAGE_BYTES must be a power of two. Configuration writes are taken at any
// time and should only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int MAX_ENTRIES  = 64,
    parameter int HEADER_BYTES = 24,
    parameter int PAGE_BYTES   = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // command channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  cmd,
    input  wire logic [REQ_W-1:0]      request_bytes,
    input  wire logic [ADDR_W-1:0]     user_address,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [ADDR_W-1:0]     data_address,
    output logic      [2:0]            status
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int LINK_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [LINK_W-1:0]  NULL_LINK  = LINK_W'(MAX_ENTRIES);
    localparam logic [LINK_W-1:0]  LAST_STEP  = LINK_W'(MAX_ENTRIES - 1);
    localparam logic [BYTES_W-1:0] HDR_BYTES  = BYTES_W'(HEADER_BYTES);
    localparam logic [BYTES_W-1:0] MIN_SPLIT  = BYTES_W'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [BYTES_W-1:0] ALIGN_MASK = BYTES_W'(ALIGN_BYTES - 1);
    localparam logic [BYTES_W-1:0] PAGE_SIZE  = BYTES_W'(PAGE_BYTES);
    localparam logic [BYTES_W-1:0] PAGE_MASK  = BYTES_W'(PAGE_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SETUP,
        S_APPEND,
        S_APPEND_LINK,
        S_WALK_START,
        S_WALK,
        S_GROW,
        S_GROW_CHECK,
        S_GRANT,
        S_SPLIT_NEW,
        S_SPLIT_OLD,
        S_DONE
    } state_t;

    // control and configuration registers
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [INIT_W-1:0]   init_reg, init_next;
    logic [LINK_W-1:0]   count_reg, count_next;
    logic [LINK_W-1:0]   first_reg, first_next;
    logic [LINK_W-1:0]   last_reg, last_next;
    logic [BYTES_W-1:0]  break_reg, break_next;
    logic                started_reg, started_next;
    logic                out_valid_reg, out_valid_next;

    // working registers
    logic                cmd_reg, cmd_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]   uaddr_reg, uaddr_next;
    logic [BYTES_W-1:0]  total_reg, total_next;
    logic [BYTES_W-1:0]  grow_reg, grow_next;
    logic [LINK_W-1:0]   idx_reg, idx_next;
    logic [LINK_W-1:0]   steps_reg, steps_next;
    logic [IDX_W-1:0]    ch_idx_reg, ch_idx_next;
    logic [ADDR_W-1:0]   ch_start_reg, ch_start_next;
    logic [BYTES_W-1:0]  ch_bytes_reg, ch_bytes_next;
    logic [LINK_W-1:0]   ch_link_reg, ch_link_next;
    logic [BYTES_W-1:0]  app_bytes_reg, app_bytes_next;
    logic                app_setup_reg, app_setup_next;
    logic [LINK_W-1:0]   prev_last_reg, prev_last_next;
    logic [IDX_W-1:0]    split_idx_reg, split_idx_next;
    logic [BYTES_W-1:0]  rest_reg, rest_next;
    logic [ADDR_W-1:0]   res_data_reg, res_data_next;
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   data_address_reg, data_address_next;
    status_t             status_reg, status_next;

    // table ports
    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic                we_start, we_bytes, we_used, we_link;
    logic [ADDR_W-1:0]   wd_start, rd_start;
    logic [BYTES_W-1:0]  wd_bytes, rd_bytes;
    logic [0:0]          wd_used, rd_used;
    logic [LINK_W-1:0]   wd_link, rd_link;

    // helpers
    logic [BYTES_W-1:0]  grow_base;
    logic [BYTES_W:0]    grow_end;
    logic [BYTES_W-1:0]  rest;
    logic                walk_hit;

    ffha_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_start_ram (
        .clk(clk), .we(we_start), .waddr(waddr), .wdata(wd_start),
        .raddr(raddr), .rdata(rd_start)
    );

    ffha_ram #(.WIDTH(BYTES_W), .DEPTH(MAX_ENTRIES)) u_bytes_ram (
        .clk(clk), .we(we_bytes), .waddr(waddr), .wdata(wd_bytes),
        .raddr(raddr), .rdata(rd_bytes)
    );

    ffha_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_used_ram (
        .clk(clk), .we(we_used), .waddr(waddr), .wdata(wd_used),
        .raddr(raddr), .rdata(rd_used)
    );

    ffha_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_link_ram (
        .clk(clk), .we(we_link), .waddr(waddr), .wdata(wd_link),
        .raddr(raddr), .rdata(rd_link)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign data_address = data_address_reg;
    assign status       = status_reg;

    // shared datapath terms
    assign grow_base = (total_reg < PAGE_SIZE) ? PAGE_SIZE : total_reg;
    assign grow_end  = {1'b0, break_reg} + {1'b0, grow_reg};
    assign rest      = ch_bytes_reg - total_reg;
    assign walk_hit  = (cmd_reg == CMD_FREE)
                       ? ((rd_start + ADDR_W'(HEADER_BYTES)) == uaddr_reg)
                       : (!rd_used[0] && (rd_bytes >= total_reg));

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        base_next         = base_reg;
        limit_next        = limit_reg;
        init_next         = init_reg;
        count_next        = count_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        break_next        = break_reg;
        started_next      = started_reg;
        out_valid_next    = out_valid_reg;
        cmd_next          = cmd_reg;
        req_next          = req_reg;
        uaddr_next        = uaddr_reg;
        total_next        = total_reg;
        grow_next         = grow_reg;
        idx_next          = idx_reg;
        steps_next        = steps_reg;
        ch_idx_next       = ch_idx_reg;
        ch_start_next     = ch_start_reg;
        ch_bytes_next     = ch_bytes_reg;
        ch_link_next      = ch_link_reg;
        app_bytes_next    = app_bytes_reg;
        app_setup_next    = app_setup_reg;
        prev_last_next    = prev_last_reg;
        split_idx_next    = split_idx_reg;
        rest_next         = rest_reg;
        res_data_next     = res_data_reg;
        res_status_next   = res_status_reg;
        data_address_next = data_address_reg;
        status_next       = status_reg;

        raddr    = idx_reg[IDX_W-1:0];
        waddr    = count_reg[IDX_W-1:0];
        we_start = 1'b0;
        we_bytes = 1'b0;
        we_used  = 1'b0;
        we_link  = 1'b0;
        wd_start = base_reg + ADDR_W'(break_reg);
        wd_bytes = app_bytes_reg;
        wd_used  = 1'b0;
        wd_link  = NULL_LINK;

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_HEAP_BASE:    base_next  = cfg_data;
                CFG_HEAP_LIMIT:   limit_next = cfg_data[LIMIT_W-1:0];
                CFG_INITIAL_HEAP: init_next  = cfg_data[INIT_W-1:0];
                default:          ;
            endcase
        end

        // result register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    req_next   = request_bytes;
                    uaddr_next = user_address;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                total_next      = ((BYTES_W'(req_reg) + ALIGN_MASK) & ~ALIGN_MASK) + HDR_BYTES;
                res_data_next   = '0;
                res_status_next = STATUS_OK;
                if (cmd_reg == CMD_FREE)
                begin
                    state_next = (uaddr_reg == '0) ? S_DONE : S_WALK_START;
                end
                else if (req_reg == '0)
                begin
                    res_status_next = STATUS_NULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = started_reg ? S_WALK_START : S_SETUP;
                end
            end

            S_SETUP:
            begin
                started_next = 1'b1;
                if ((init_reg != '0) && (LIMIT_W'(init_reg) <= limit_reg))
                begin
                    app_bytes_next = BYTES_W'(init_reg);
                    app_setup_next = 1'b1;
                    state_next     = S_APPEND;
                end
                else
                begin
                    state_next = S_WALK_START;
                end
            end

            // new free block at the break
            S_APPEND:
            begin
                we_start       = 1'b1;
                we_bytes       = 1'b1;
                we_used        = 1'b1;
                we_link        = 1'b1;
                prev_last_next = last_reg;
                ch_idx_next    = count_reg[IDX_W-1:0];
                ch_start_next  = wd_start;
                ch_bytes_next  = app_bytes_reg;
                ch_link_next   = NULL_LINK;
                last_next      = count_reg;
                count_next     = count_reg + LINK_W'(1);
                break_next     = break_reg + app_bytes_reg;
                if (last_reg < count_reg)
                begin
                    state_next = S_APPEND_LINK;
                end
                else
                begin
                    first_next = count_reg;
                    state_next = app_setup_reg ? S_WALK_START : S_GRANT;
                end
            end

            S_APPEND_LINK:
            begin
                waddr      = prev_last_reg[IDX_W-1:0];
                we_link    = 1'b1;
                wd_link    = LINK_W'(ch_idx_reg);
                state_next = app_setup_reg ? S_WALK_START : S_GRANT;
            end

            S_WALK_START:
            begin
                raddr      = first_reg[IDX_W-1:0];
                idx_next   = first_reg;
                steps_next = '0;
                if (first_reg < count_reg)
                begin
                    state_next = S_WALK;
                end
                else if (cmd_reg == CMD_FREE)
                begin
                    res_status_next = STATUS_UNKNOWN;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end

            // one list entry per cycle
            S_WALK:
            begin
                if (walk_hit)
                begin
                    if (cmd_reg == CMD_FREE)
                    begin
                        waddr      = idx_reg[IDX_W-1:0];
                        we_used    = 1'b1;
                        wd_used    = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ch_idx_next   = idx_reg[IDX_W-1:0];
                        ch_start_next = rd_start;
                        ch_bytes_next = rd_bytes;
                        ch_link_next  = rd_link;
                        state_next    = S_GRANT;
                    end
                end
                else if ((steps_reg == LAST_STEP) || (rd_link >= count_reg))
                begin
                    if (cmd_reg == CMD_FREE)
                    begin
                        res_status_next = STATUS_UNKNOWN;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_GROW;
                    end
                end
                else
                begin
                    raddr      = rd_link[IDX_W-1:0];
                    idx_next   = rd_link;
                    steps_next = steps_reg + LINK_W'(1);
                end
            end

            S_GROW:
            begin
                grow_next  = (grow_base + PAGE_MASK) & ~PAGE_MASK;
                state_next = S_GROW_CHECK;
            end

            S_GROW_CHECK:
            begin
                if (grow_end > (BYTES_W + 1)'(limit_reg))
                begin
                    res_status_next = STATUS_OOM;
                    state_next      = S_DONE;
                end
                else if (count_reg >= NULL_LINK)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    app_bytes_next = grow_reg;
                    app_setup_next = 1'b0;
                    state_next     = S_APPEND;
                end
            end

            S_GRANT:
            begin
                waddr         = ch_idx_reg;
                we_used       = 1'b1;
                wd_used       = 1'b1;
                rest_next     = rest;
                res_data_next = ch_start_reg + ADDR_W'(HEADER_BYTES);
                if ((rest >= MIN_SPLIT) && (count_reg < NULL_LINK))
                begin
                    state_next = S_SPLIT_NEW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // tail of the split block
            S_SPLIT_NEW:
            begin
                we_start       = 1'b1;
                we_bytes       = 1'b1;
                we_used        = 1'b1;
                we_link        = 1'b1;
                wd_start       = ch_start_reg + ADDR_W'(total_reg);
                wd_bytes       = rest_reg;
                wd_used        = 1'b0;
                wd_link        = ch_link_reg;
                split_idx_next = count_reg[IDX_W-1:0];
                count_next     = count_reg + LINK_W'(1);
                if (last_reg == LINK_W'(ch_idx_reg))
                begin
                    last_next = count_reg;
                end
                state_next = S_SPLIT_OLD;
            end

            S_SPLIT_OLD:
            begin
                waddr      = ch_idx_reg;
                we_bytes   = 1'b1;
                we_link    = 1'b1;
                wd_bytes   = total_reg;
                wd_link    = LINK_W'(split_idx_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    data_address_next = res_data_reg;
                    status_next       = res_status_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= ADDR_W'(65536);
            limit_reg     <= LIMIT_W'(1048576);
            init_reg      <= INIT_W'(16 * 1024);
            count_reg     <= '0;
            first_reg     <= NULL_LINK;
            last_reg      <= NULL_LINK;
            break_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            init_reg      <= init_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            break_reg     <= break_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        req_reg          <= req_next;
        uaddr_reg        <= uaddr_next;
        total_reg        <= total_next;
        grow_reg         <= grow_next;
        idx_reg          <= idx_next;
        steps_reg        <= steps_next;
        ch_idx_reg       <= ch_idx_next;
        ch_start_reg     <= ch_start_next;
        ch_bytes_reg     <= ch_bytes_next;
        ch_link_reg      <= ch_link_next;
        app_bytes_reg    <= app_bytes_next;
        app_setup_reg    <= app_setup_next;
        prev_last_reg    <= prev_last_next;
        split_idx_reg    <= split_idx_next;
        rest_reg         <= rest_next;
        res_data_reg     <= res_data_next;
        res_status_reg   <= res_status_next;
        data_address_reg <= data_address_next;
        status_reg       <= status_next;
    end

endmodule

`default_nettype wire
